// ----- rtl/core/rop_pkg.sv -----
// Shared widths, constants and pipeline sideband type for the overlap force unit.
package rop_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 15;
   localparam int INDEX_BITS = 20;
   localparam int FORCE_BITS = 48;

   localparam int DIFF_BITS  = COORD_BITS + 2;             // signed doubled-center delta
   localparam int MAG_BITS   = COORD_BITS + 1;             // |delta|, signed extent
   localparam int AREA_BITS  = 2 * COORD_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int LEN2_BITS  = SQ_BITS + 1;
   localparam int SQRT_STEPS = (LEN2_BITS + 2 * FRAC_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * SQRT_STEPS;
   localparam int REM_BITS   = SQRT_STEPS + 3;
   localparam int QUOT_BITS  = FRAC_BITS + 1;
   localparam int DIV_BITS   = SQRT_STEPS + FRAC_BITS;
   localparam int PROD_BITS  = AREA_BITS + QUOT_BITS;

   localparam int REQ_BITS       = 8 * COORD_BITS + 2 * INDEX_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((2 * FORCE_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic                 valid;
      logic                 live;      // distinct blocks with positive-area overlap
      logic                 coin;      // centers coincide
      logic                 a_lt_b;
      logic                 neg_x;
      logic                 neg_y;
      logic [AREA_BITS-1:0] area;
      logic [MAG_BITS-1:0]  adx;
      logic [MAG_BITS-1:0]  ady;
   } side_type;

endpackage

// ----- rtl/core/rop_front.sv -----
// Overlap extents, area, center deltas and squared distance (three stages).
module rop_front
   import rop_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [COORD_BITS-1:0] a_llx,
   input  logic [COORD_BITS-1:0] a_lly,
   input  logic [COORD_BITS-1:0] a_urx,
   input  logic [COORD_BITS-1:0] a_ury,
   input  logic [COORD_BITS-1:0] b_llx,
   input  logic [COORD_BITS-1:0] b_lly,
   input  logic [COORD_BITS-1:0] b_urx,
   input  logic [COORD_BITS-1:0] b_ury,
   input  logic [INDEX_BITS-1:0] a_index,
   input  logic [INDEX_BITS-1:0] b_index,
   output side_type              side_o,
   output logic [LEN2_BITS-1:0]  len2_o
);

   // stage 1
   logic                        v1_ff, v1_in;
   logic                        dist_ff, dist_in;
   logic                        altb_ff, altb_in;
   logic signed [MAG_BITS-1:0]  w_ff, w_in, h_ff, h_in;
   logic signed [DIFF_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;

   logic [COORD_BITS-1:0] lx, ux, ly, uy;
   logic [MAG_BITS-1:0]   sax, sbx, say, sby;

   always_comb begin
      lx = (a_llx > b_llx) ? a_llx : b_llx;
      ux = (a_urx < b_urx) ? a_urx : b_urx;
      ly = (a_lly > b_lly) ? a_lly : b_lly;
      uy = (a_ury < b_ury) ? a_ury : b_ury;
      w_in = $signed({1'b0, ux}) - $signed({1'b0, lx});
      h_in = $signed({1'b0, uy}) - $signed({1'b0, ly});
      sax = {1'b0, a_llx} + {1'b0, a_urx};
      sbx = {1'b0, b_llx} + {1'b0, b_urx};
      say = {1'b0, a_lly} + {1'b0, a_ury};
      sby = {1'b0, b_lly} + {1'b0, b_ury};
      dx_in = $signed({1'b0, sax}) - $signed({1'b0, sbx});
      dy_in = $signed({1'b0, say}) - $signed({1'b0, sby});
      dist_in = (a_index != b_index);
      altb_in = (a_index < b_index);
      v1_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff <= dist_in;
         altb_ff <= altb_in;
         w_ff    <= w_in;
         h_ff    <= h_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
      end
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
      end
   end

   // stage 2: products
   side_type                side2_ff, side2_in;
   logic [SQ_BITS-1:0]      sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic signed [DIFF_BITS-1:0] ndx, ndy;
   logic [DIFF_BITS-1:0]    abx, aby;

   always_comb begin
      ndx = -dx_ff;
      ndy = -dy_ff;
      abx = dx_ff[DIFF_BITS-1] ? ndx : dx_ff;
      aby = dy_ff[DIFF_BITS-1] ? ndy : dy_ff;
      side2_in.valid  = v1_ff;
      side2_in.live   = dist_ff && (w_ff > 0) && (h_ff > 0);
      side2_in.coin   = (dx_ff == 0) && (dy_ff == 0);
      side2_in.a_lt_b = altb_ff;
      side2_in.neg_x  = dx_ff[DIFF_BITS-1];
      side2_in.neg_y  = dy_ff[DIFF_BITS-1];
      side2_in.area   = w_ff[COORD_BITS-1:0] * h_ff[COORD_BITS-1:0];
      side2_in.adx    = abx[MAG_BITS-1:0];
      side2_in.ady    = aby[MAG_BITS-1:0];
      sqx_in = side2_in.adx * side2_in.adx;
      sqy_in = side2_in.ady * side2_in.ady;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
      end
      if (reset) begin
         side2_ff <= '0;
      end else if (advance) begin
         side2_ff <= side2_in;
      end
   end

   // stage 3: squared length
   side_type             side3_ff;
   logic [LEN2_BITS-1:0] len2_ff, len2_in;

   assign len2_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         len2_ff  <= len2_in;
      end
      if (reset) begin
         side3_ff <= '0;
      end else if (advance) begin
         side3_ff <= side2_ff;
      end
   end

   assign side_o = side3_ff;
   assign len2_o = len2_ff;

endmodule

// ----- rtl/core/rop_sqrt.sv -----
// Pipelined integer square root of len2 scaled by 2^(2*FRAC_BITS), one root bit per stage.
module rop_sqrt
   import rop_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  side_type              side_i,
   input  logic [LEN2_BITS-1:0]  len2_i,
   output side_type              side_o,
   output logic [SQRT_STEPS-1:0] root_o
);

   side_type                side_ff [SQRT_STEPS];
   logic [RAD_BITS-1:0]     rad_ff  [SQRT_STEPS];
   logic [SQRT_STEPS-1:0]   root_ff [SQRT_STEPS];
   logic [REM_BITS-1:0]     rem_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      side_type              side_cur;
      logic [RAD_BITS-1:0]   rad_cur, rad_in;
      logic [SQRT_STEPS-1:0] root_cur, root_in;
      logic [REM_BITS-1:0]   rem_cur, rem_in, rem_sh, trial;
      logic                  take;

      if (k == 0) begin : g_first
         assign side_cur = side_i;
         assign rad_cur  = RAD_BITS'(len2_i) << (2 * FRAC_BITS);
         assign root_cur = '0;
         assign rem_cur  = '0;
      end else begin : g_next
         assign side_cur = side_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
      end

      always_comb begin
         rem_sh  = {rem_cur[REM_BITS-3:0], rad_cur[RAD_BITS-1 -: 2]};
         trial   = REM_BITS'({root_cur, 2'b01});
         take    = (rem_sh >= trial);
         rem_in  = take ? (rem_sh - trial) : rem_sh;
         root_in = {root_cur[SQRT_STEPS-2:0], take};
         rad_in  = rad_cur << 2;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[k]  <= rad_in;
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
         end
         if (reset) begin
            side_ff[k] <= '0;
         end else if (advance) begin
            side_ff[k] <= side_cur;
         end
      end
   end

   assign side_o = side_ff[SQRT_STEPS-1];
   assign root_o = root_ff[SQRT_STEPS-1];

endmodule

// ----- rtl/core/rop_div.sv -----
// Pipelined restoring divider, x and y lanes: |d| * 2^(2*FRAC_BITS) / root, one bit per stage.
module rop_div
   import rop_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  side_type              side_i,
   input  logic [SQRT_STEPS-1:0] root_i,
   output side_type              side_o,
   output logic [QUOT_BITS-1:0]  qx_o,
   output logic [QUOT_BITS-1:0]  qy_o
);

   side_type              side_ff [QUOT_BITS];
   logic [SQRT_STEPS-1:0] den_ff  [QUOT_BITS];
   logic [DIV_BITS-1:0]   rx_ff   [QUOT_BITS];
   logic [DIV_BITS-1:0]   ry_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0]  qx_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0]  qy_ff   [QUOT_BITS];

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_step
      side_type              side_cur;
      logic [SQRT_STEPS-1:0] den_cur;
      logic [DIV_BITS-1:0]   rx_cur, ry_cur, rx_in, ry_in, dsh;
      logic [QUOT_BITS-1:0]  qx_cur, qy_cur, qx_in, qy_in;
      logic                  gx, gy;

      if (j == 0) begin : g_first
         assign side_cur = side_i;
         assign den_cur  = root_i;
         assign rx_cur   = DIV_BITS'(side_i.adx) << (2 * FRAC_BITS);
         assign ry_cur   = DIV_BITS'(side_i.ady) << (2 * FRAC_BITS);
         assign qx_cur   = '0;
         assign qy_cur   = '0;
      end else begin : g_next
         assign side_cur = side_ff[j-1];
         assign den_cur  = den_ff[j-1];
         assign rx_cur   = rx_ff[j-1];
         assign ry_cur   = ry_ff[j-1];
         assign qx_cur   = qx_ff[j-1];
         assign qy_cur   = qy_ff[j-1];
      end

      always_comb begin
         dsh   = DIV_BITS'(den_cur) << (FRAC_BITS - j);
         gx    = (rx_cur >= dsh);
         gy    = (ry_cur >= dsh);
         rx_in = gx ? (rx_cur - dsh) : rx_cur;
         ry_in = gy ? (ry_cur - dsh) : ry_cur;
         qx_in = {qx_cur[QUOT_BITS-2:0], gx};
         qy_in = {qy_cur[QUOT_BITS-2:0], gy};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[j]  <= den_cur;
            rx_ff[j]   <= rx_in;
            ry_ff[j]   <= ry_in;
            qx_ff[j]   <= qx_in;
            qy_ff[j]   <= qy_in;
         end
         if (reset) begin
            side_ff[j] <= '0;
         end else if (advance) begin
            side_ff[j] <= side_cur;
         end
      end
   end

   assign side_o = side_ff[QUOT_BITS-1];
   assign qx_o   = qx_ff[QUOT_BITS-1];
   assign qy_o   = qy_ff[QUOT_BITS-1];

endmodule

// ----- rtl/core/rect_overlap_repulsion_force_unit.sv -----
// Rectangle overlap repulsion force unit, pipeline top level.
//
// Takes one rectangle pair per cycle and returns the force on rectangle A:
// overlap area times the Q1.15 unit vector from B's center to A's center,
// or zero with rsp_tuser low when the blocks are the same or do not overlap.
// Throughput is one word per cycle unless stalled; there are 3 front stages,
// 33 square-root stages (one root bit each), 16 divider stages (one quotient
// bit each), one multiply stage and the output register. The whole pipeline
// advances together whenever the output register is empty or being taken,
// so req_tready follows rsp_tready once the output holds a word.
module rect_overlap_repulsion_force_unit
   import rop_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // a_llx, a_lly, a_urx, a_ury, b_llx, b_lly, b_urx, b_ury, a_index, b_index
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // force_x, force_y
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // overlapping
   output logic                      rsp_tuser
);

   localparam int IDX_LO = 8 * COORD_BITS;

   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   side_type              front_side, sqrt_side, div_side;
   logic [LEN2_BITS-1:0]  len2;
   logic [SQRT_STEPS-1:0] root;
   logic [QUOT_BITS-1:0]  qx, qy;

   rop_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .a_llx    (req_tdata[0*COORD_BITS +: COORD_BITS]),
      .a_lly    (req_tdata[1*COORD_BITS +: COORD_BITS]),
      .a_urx    (req_tdata[2*COORD_BITS +: COORD_BITS]),
      .a_ury    (req_tdata[3*COORD_BITS +: COORD_BITS]),
      .b_llx    (req_tdata[4*COORD_BITS +: COORD_BITS]),
      .b_lly    (req_tdata[5*COORD_BITS +: COORD_BITS]),
      .b_urx    (req_tdata[6*COORD_BITS +: COORD_BITS]),
      .b_ury    (req_tdata[7*COORD_BITS +: COORD_BITS]),
      .a_index  (req_tdata[IDX_LO +: INDEX_BITS]),
      .b_index  (req_tdata[IDX_LO + INDEX_BITS +: INDEX_BITS]),
      .side_o   (front_side),
      .len2_o   (len2)
   );

   rop_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .side_i  (front_side),
      .len2_i  (len2),
      .side_o  (sqrt_side),
      .root_o  (root)
   );

   rop_div u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .side_i  (sqrt_side),
      .root_i  (root),
      .side_o  (div_side),
      .qx_o    (qx),
      .qy_o    (qy)
   );

   // multiply stage; coincident centers push along x by index order
   logic                 mv_ff, mlive_ff, mnx_ff, mny_ff;
   logic                 mnx_in;
   logic [PROD_BITS-1:0] px_ff, py_ff, px_in, py_in;
   logic [QUOT_BITS-1:0] ux, uy;

   always_comb begin
      ux     = div_side.coin ? QUOT_BITS'(1) << FRAC_BITS : qx;
      uy     = div_side.coin ? '0 : qy;
      mnx_in = div_side.coin ? div_side.a_lt_b : div_side.neg_x;
      px_in  = div_side.area * ux;
      py_in  = div_side.area * uy;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mlive_ff <= div_side.live;
         mnx_ff   <= mnx_in;
         mny_ff   <= div_side.neg_y;
         px_ff    <= px_in;
         py_ff    <= py_in;
      end
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (advance) begin
         mv_ff <= div_side.valid;
      end
   end

   // output register
   logic                         ov_ff;
   logic                         ol_ff, ol_in;
   logic signed [FORCE_BITS-1:0] fx_ff, fy_ff, fx_in, fy_in, fxp, fyp;

   always_comb begin
      fxp   = FORCE_BITS'(px_ff);
      fyp   = FORCE_BITS'(py_ff);
      fx_in = !mlive_ff ? '0 : (mnx_ff ? -fxp : fxp);
      fy_in = !mlive_ff ? '0 : (mny_ff ? -fyp : fyp);
      ol_in = mlive_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         ol_ff <= ol_in;
      end
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (advance) begin
         ov_ff <= mv_ff;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({fy_ff, fx_ff});
   assign rsp_tuser  = ol_ff;

endmodule

// ----- verif/testbench.sv -----
// Testbench for the rectangle overlap repulsion force unit.
`timescale 1ns / 1ps

module testbench;
   import rop_pkg::*;

   typedef struct {
      logic [47:0] fx;
      logic [47:0] fy;
      logic        ovl;
   } force_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic rsp_tuser;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int sent = 0;
   int got = 0;
   int live_seen = 0;
   force_type pending_forces[$];

   rect_overlap_repulsion_force_unit uut (.*);

   always #1 clock = ~clock;

   // floor(sqrt(x)), bit by bit
   function automatic logic [63:0] root_floor(logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (128'(c) * 128'(c) <= x) r = c;
      end
      return r;
   endfunction

   function automatic logic [47:0] scale_force(logic [63:0] area, logic [63:0] umag,
                                               bit neg);
      logic [63:0] lim;
      logic [63:0] mag;
      lim = (64'd1 << 47) - 1;
      if (neg) lim = lim + 1;
      if (umag != 0 && area > lim / umag) mag = lim;
      else mag = area * umag;
      if (neg) mag = 64'd0 - mag;
      return mag[47:0];
   endfunction

   function automatic force_type predict_force(logic [REQ_TDATA_BITS-1:0] d);
      force_type f;
      longint allx, ally, aurx, aury, bllx, blly, burx, bury;
      longint lx, ux, ly, uy, w, h, dx, dy;
      logic [19:0] ai, bi;
      logic [63:0] area, adx, ady, s, mx, my;
      allx = 64'(d[15:0]); ally = 64'(d[31:16]);
      aurx = 64'(d[47:32]); aury = 64'(d[63:48]);
      bllx = 64'(d[79:64]); blly = 64'(d[95:80]);
      burx = 64'(d[111:96]); bury = 64'(d[127:112]);
      ai = d[147:128]; bi = d[167:148];
      f.fx = 0; f.fy = 0; f.ovl = 0;
      lx = allx > bllx ? allx : bllx;
      ux = aurx < burx ? aurx : burx;
      ly = ally > blly ? ally : blly;
      uy = aury < bury ? aury : bury;
      w = ux - lx; h = uy - ly;
      if (ai == bi || w <= 0 || h <= 0) return f;
      area = w * h;
      dx = (allx + aurx) - (bllx + burx);
      dy = (ally + aury) - (blly + bury);
      if (dx == 0 && dy == 0) begin
         f.fx = scale_force(area, 64'd1 << FRAC_BITS, ai < bi);
      end else begin
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         s = root_floor(128'(adx * adx + ady * ady) << (2 * FRAC_BITS));
         mx = 64'((128'(adx) << (2 * FRAC_BITS)) / s);
         my = 64'((128'(ady) << (2 * FRAC_BITS)) / s);
         f.fx = scale_force(area, mx, dx < 0);
         f.fy = scale_force(area, my, dy < 0);
      end
      f.ovl = 1;
      return f;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] seen, logic [47:0] want);
      errors++;
      $display("mismatch word %0d %s: got %h expected %h", got, what, seen, want);
   endtask

   task automatic send_pair(logic [15:0] c[8], logic [19:0] ai, logic [19:0] bi);
      logic [REQ_TDATA_BITS-1:0] d;
      d = '0;
      for (int i = 0; i < 8; i++) d[16*i +: 16] = c[i];
      d[128 +: 20] = ai;
      d[148 +: 20] = bi;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_forces.push_back(predict_force(d));
      sent++;
   endtask

   task automatic go_idle();
      req_tvalid <= 0;
   endtask

   // receiver side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            force_type e;
            if (pending_forces.size() == 0) begin
               errors++;
               $display("unexpected word with no prediction");
            end else begin
               e = pending_forces.pop_front();
               if (rsp_tdata[47:0] !== e.fx) report_mismatch("force_x", rsp_tdata[47:0], e.fx);
               if (rsp_tdata[95:48] !== e.fy)
                  report_mismatch("force_y", rsp_tdata[95:48], e.fy);
               if (rsp_tuser !== e.ovl)
                  report_mismatch("overlapping", 48'(rsp_tuser), 48'(e.ovl));
               if (e.ovl) live_seen++;
            end
            got++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   task automatic test_directed();
      logic [15:0] c[8];
      // identical rects, same block: no force
      c = '{0, 0, 100, 100, 0, 0, 100, 100};
      send_pair(c, 5, 5);
      // coincident centers, both tie directions
      send_pair(c, 5, 6);
      send_pair(c, 6, 5);
      // full-range rectangles
      c = '{0, 0, 16'hffff, 16'hffff, 0, 0, 16'hffff, 16'hffff};
      send_pair(c, 0, 20'hfffff);
      send_pair(c, 20'hfffff, 0);
      // corner touch only, zero area
      c = '{0, 0, 10, 10, 10, 10, 20, 20};
      send_pair(c, 1, 2);
      // edge share
      c = '{0, 0, 10, 10, 10, 0, 20, 10};
      send_pair(c, 1, 2);
      // malformed A
      c = '{50, 50, 10, 10, 0, 0, 100, 100};
      send_pair(c, 1, 2);
      // pure x and y offsets, all signs
      c = '{0, 0, 100, 100, 50, 0, 150, 100};
      send_pair(c, 1, 2);
      c = '{50, 0, 150, 100, 0, 0, 100, 100};
      send_pair(c, 1, 2);
      c = '{0, 0, 100, 100, 0, 50, 100, 150};
      send_pair(c, 1, 2);
      c = '{0, 50, 100, 150, 0, 0, 100, 100};
      send_pair(c, 1, 2);
      // diagonal, extreme corners
      c = '{0, 0, 16'hffff, 16'hffff, 1, 1, 16'hffff, 16'hffff};
      send_pair(c, 3, 4);
      c = '{16'hfffe, 16'hfffe, 16'hffff, 16'hffff, 0, 0, 16'hffff, 16'hffff};
      send_pair(c, 3, 4);
      c = '{0, 0, 1, 1, 0, 0, 16'hffff, 16'hffff};
      send_pair(c, 20'haaaaa, 20'h55555);
      go_idle();
   endtask

   task automatic test_random(int n);
      logic [15:0] c[8];
      logic [15:0] x0, y0, w0, h0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 7) begin
            // pair placed around a common spot, so it often overlaps
            w0 = $urandom_range(1, 3) == 1 ? rnd16() : 16'($urandom_range(1, 300));
            h0 = $urandom_range(1, 3) == 1 ? rnd16() : 16'($urandom_range(1, 300));
            x0 = rnd16(); y0 = rnd16();
            c[0] = x0; c[1] = y0;
            c[2] = (32'(x0) + w0 > 16'hffff) ? 16'hffff : x0 + w0;
            c[3] = (32'(y0) + h0 > 16'hffff) ? 16'hffff : y0 + h0;
            c[4] = x0 + 16'($urandom_range(0, 200)) - 16'd100;
            c[5] = y0 + 16'($urandom_range(0, 200)) - 16'd100;
            c[6] = c[4] + 16'($urandom_range(1, 400));
            c[7] = c[5] + 16'($urandom_range(1, 400));
         end else begin
            for (int k = 0; k < 8; k++) c[k] = rnd16();
         end
         if ($urandom_range(19) == 0) begin
            logic [19:0] ix;
            ix = 20'($urandom);
            send_pair(c, ix, ix);
         end else begin
            send_pair(c, 20'($urandom), 20'($urandom));
         end
      end
      go_idle();
   endtask

   task automatic drain();
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      drain();
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random(160);
      send_idle_pct = 76; recv_stall_pct = 0;  test_random(160);
      send_idle_pct = 0;  recv_stall_pct = 76; test_random(160);
      send_idle_pct = 10; recv_stall_pct = 10; test_random(160);
      drain();
      $display("%0d pairs sent, %0d force words checked, %0d with overlap,", sent, got,
               live_seen);
      $display("across free-running, sender-idle, receiver-stall and mixed phases");
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/rop_pkg.sv
rtl/core/rop_front.sv
rtl/core/rop_sqrt.sv
rtl/core/rop_div.sv
rtl/core/rect_overlap_repulsion_force_unit.sv
verif/testbench.sv
